### src/efg_pkg.sv
// Shared types, constants and the quarter-wave sine table for the ellipse fan generator.
// No dependencies.
package efg_pkg;

  localparam int SEG_W   = 7;
  localparam int ANG_W   = 9;
  localparam int SINE_W  = 15;
  localparam int TRIG_W  = 16;
  localparam int FRAC_W  = 14;
  localparam int COLOR_W = 8;
  localparam int TOTAL_W = 32;

  localparam logic [ANG_W-1:0] QUARTER_TURN  = 9'd90;
  localparam logic [ANG_W-1:0] HALF_TURN     = 9'd180;
  localparam logic [ANG_W-1:0] THREE_QUARTER = 9'd270;
  localparam logic [ANG_W-1:0] FULL_TURN     = 9'd360;

  typedef logic [SEG_W-1:0] seg_t;
  typedef logic [ANG_W-1:0] ang_t;
  typedef logic signed [TRIG_W-1:0] trig_t;

  // start of one ellipse: triangle count and angle step in degrees
  typedef struct packed {
    logic go;
    seg_t count;
    ang_t step;
  } efg_ctl_t;

  // round(16384 * sin(d)), d = 0..90
  function automatic logic [SINE_W-1:0] quarter_sine(input logic [6:0] d);
    logic [SINE_W-1:0] v;
    case (d)
      7'd0: v = 15'd0;         7'd1: v = 15'd286;       7'd2: v = 15'd572;
      7'd3: v = 15'd857;       7'd4: v = 15'd1143;      7'd5: v = 15'd1428;
      7'd6: v = 15'd1713;      7'd7: v = 15'd1997;      7'd8: v = 15'd2280;
      7'd9: v = 15'd2563;      7'd10: v = 15'd2845;     7'd11: v = 15'd3126;
      7'd12: v = 15'd3406;     7'd13: v = 15'd3686;     7'd14: v = 15'd3964;
      7'd15: v = 15'd4240;     7'd16: v = 15'd4516;     7'd17: v = 15'd4790;
      7'd18: v = 15'd5063;     7'd19: v = 15'd5334;     7'd20: v = 15'd5604;
      7'd21: v = 15'd5872;     7'd22: v = 15'd6138;     7'd23: v = 15'd6402;
      7'd24: v = 15'd6664;     7'd25: v = 15'd6924;     7'd26: v = 15'd7182;
      7'd27: v = 15'd7438;     7'd28: v = 15'd7692;     7'd29: v = 15'd7943;
      7'd30: v = 15'd8192;     7'd31: v = 15'd8438;     7'd32: v = 15'd8682;
      7'd33: v = 15'd8923;     7'd34: v = 15'd9162;     7'd35: v = 15'd9397;
      7'd36: v = 15'd9630;     7'd37: v = 15'd9860;     7'd38: v = 15'd10087;
      7'd39: v = 15'd10311;    7'd40: v = 15'd10531;    7'd41: v = 15'd10749;
      7'd42: v = 15'd10963;    7'd43: v = 15'd11174;    7'd44: v = 15'd11381;
      7'd45: v = 15'd11585;    7'd46: v = 15'd11786;    7'd47: v = 15'd11982;
      7'd48: v = 15'd12176;    7'd49: v = 15'd12365;    7'd50: v = 15'd12551;
      7'd51: v = 15'd12733;    7'd52: v = 15'd12911;    7'd53: v = 15'd13085;
      7'd54: v = 15'd13255;    7'd55: v = 15'd13421;    7'd56: v = 15'd13583;
      7'd57: v = 15'd13741;    7'd58: v = 15'd13894;    7'd59: v = 15'd14044;
      7'd60: v = 15'd14189;    7'd61: v = 15'd14330;    7'd62: v = 15'd14466;
      7'd63: v = 15'd14598;    7'd64: v = 15'd14726;    7'd65: v = 15'd14849;
      7'd66: v = 15'd14968;    7'd67: v = 15'd15082;    7'd68: v = 15'd15191;
      7'd69: v = 15'd15296;    7'd70: v = 15'd15396;    7'd71: v = 15'd15491;
      7'd72: v = 15'd15582;    7'd73: v = 15'd15668;    7'd74: v = 15'd15749;
      7'd75: v = 15'd15826;    7'd76: v = 15'd15897;    7'd77: v = 15'd15964;
      7'd78: v = 15'd16026;    7'd79: v = 15'd16083;    7'd80: v = 15'd16135;
      7'd81: v = 15'd16182;    7'd82: v = 15'd16225;    7'd83: v = 15'd16262;
      7'd84: v = 15'd16294;    7'd85: v = 15'd16322;    7'd86: v = 15'd16344;
      7'd87: v = 15'd16362;    7'd88: v = 15'd16374;    7'd89: v = 15'd16382;
      7'd90: v = 15'd16384;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // signed Q1.14 sine of an angle in 0..359 degrees
  function automatic trig_t sine_deg(input ang_t a);
    logic [6:0]        r;
    logic              neg;
    logic [SINE_W-1:0] m;
    if (a < QUARTER_TURN) begin
      r   = a[6:0];
      neg = 1'b0;
    end else if (a < HALF_TURN) begin
      r   = 7'(HALF_TURN - a);
      neg = 1'b0;
    end else if (a < THREE_QUARTER) begin
      r   = 7'(a - HALF_TURN);
      neg = 1'b1;
    end else begin
      r   = 7'(FULL_TURN - a);
      neg = 1'b1;
    end
    m = quarter_sine(r);
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

endpackage

### src/efg_div.sv
// Restoring divider: 360 / segment count, one quotient bit per cycle.
// Depends on efg_pkg.
module efg_div
  import efg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  seg_t divisor,
  output logic done,
  output ang_t quot
);

  logic            busy_r;
  logic            done_r;
  logic [3:0]      cnt_r;
  seg_t            rem_r;
  seg_t            dvs_r;
  ang_t            q_r;
  logic [SEG_W:0]  trial;
  logic [SEG_W:0]  diff;
  logic            ge;

  always_comb begin
    trial = {rem_r, q_r[ANG_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = trial >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'(ANG_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out of q_r while quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= FULL_TURN;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[SEG_W-1:0] : trial[SEG_W-1:0];
      q_r   <= {q_r[ANG_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

### src/efg_rim.sv
// Rim point pipeline: angle walk, sine/cosine lookup, radius multiply, round and
// saturate; writes point j of the fan into the point buffer. Depends on efg_pkg.
module efg_rim
  import efg_pkg::*;
#(
  parameter int CW = 16,
  parameter int AW = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  efg_ctl_t             ctl,
  input  logic signed [CW-1:0] center_x,
  input  logic signed [CW-1:0] center_y,
  input  logic signed [CW-1:0] scale_x,
  input  logic signed [CW-1:0] scale_y,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [CW-1:0]        wr_x,
  output logic [CW-1:0]        wr_y,
  output logic                 done
);

  localparam int PW = CW + TRIG_W;
  localparam logic signed [PW:0] RND = (PW+1)'(2 ** (FRAC_W - 1));

  logic                 gen_r;
  seg_t                 idx_r;
  ang_t                 ang_r;
  seg_t                 cnt_r;
  ang_t                 step_r;
  logic                 s1_v_r;
  seg_t                 s1_idx_r;
  trig_t                s1_sin_r;
  trig_t                s1_cos_r;
  logic                 s2_v_r;
  seg_t                 s2_idx_r;
  logic signed [PW-1:0] s2_px_r;
  logic signed [PW-1:0] s2_py_r;
  ang_t                 ang_cos;
  logic [ANG_W:0]       ang_sum;
  ang_t                 ang_nxt;

  // center + round(p / 2^14), clamped to the coordinate range
  function automatic logic [CW-1:0] rim_sat(input logic signed [PW-1:0] p,
                                            input logic signed [CW-1:0] c);
    logic signed [PW:0]   t;
    logic signed [PW:0]   sh;
    logic signed [PW+1:0] s;
    logic                 fits;
    t    = $signed({p[PW-1], p}) + RND;
    sh   = t >>> FRAC_W;
    s    = $signed({sh[PW], sh}) + $signed({{(PW+2-CW){c[CW-1]}}, c});
    fits = (&s[PW+1:CW-1]) | ~(|s[PW+1:CW-1]);
    if (fits)
      return s[CW-1:0];
    return s[PW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  always_comb begin
    ang_cos = (ang_r >= THREE_QUARTER) ? ang_r - THREE_QUARTER : ang_r + QUARTER_TURN;
    ang_sum = {1'b0, ang_r} + {1'b0, step_r};
    ang_nxt = (ang_sum >= {1'b0, FULL_TURN}) ? ANG_W'(ang_sum - {1'b0, FULL_TURN})
                                             : ang_sum[ANG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r  <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= gen_r;
      s2_v_r <= s1_v_r;
      if (ctl.go)
        gen_r <= 1'b1;
      else if (gen_r && idx_r == cnt_r)
        gen_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go) begin
      idx_r  <= '0;
      ang_r  <= QUARTER_TURN;
      cnt_r  <= ctl.count;
      step_r <= ctl.step;
    end else if (gen_r) begin
      idx_r <= idx_r + 1'b1;
      ang_r <= ang_nxt;
    end
    s1_idx_r <= idx_r;
    s1_sin_r <= sine_deg(ang_r);
    s1_cos_r <= sine_deg(ang_cos);
    s2_idx_r <= s1_idx_r;
    s2_px_r  <= scale_x * s1_cos_r;
    s2_py_r  <= scale_y * s1_sin_r;
  end

  assign wr_en   = s2_v_r;
  assign wr_addr = s2_idx_r[AW-1:0];
  assign wr_x    = rim_sat(s2_px_r, center_x);
  assign wr_y    = rim_sat(s2_py_r, center_y);
  assign done    = s2_v_r && (s2_idx_r == cnt_r);

endmodule

### src/efg_emit.sv
// Rim point buffer and triangle readout: reads points behind the writer, pairs
// each with the previous one, keeps the vertex total and drives the result word.
// Depends on efg_pkg.
module efg_emit
  import efg_pkg::*;
#(
  parameter int CW    = 16,
  parameter int AW    = 7,
  parameter int DEPTH = 65
) (
  input  logic               clk,
  input  logic               rst_n,
  input  efg_ctl_t           ctl,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [CW-1:0]      wr_x,
  input  logic [CW-1:0]      wr_y,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [CW-1:0]      rim_a_x,
  output logic [CW-1:0]      rim_a_y,
  output logic [CW-1:0]      rim_b_x,
  output logic [CW-1:0]      rim_b_y,
  output logic               last,
  output logic [TOTAL_W-1:0] total,
  output logic               done
);

  typedef struct packed {
    logic [CW-1:0]      a_x;
    logic [CW-1:0]      a_y;
    logic [CW-1:0]      b_x;
    logic [CW-1:0]      b_y;
    logic               last;
    logic [TOTAL_W-1:0] total;
  } tri_t;

  logic [2*CW-1:0]    mem [DEPTH];
  logic [2*CW-1:0]    rd_data_r;

  logic               act_r;
  seg_t               cnt_r;
  seg_t               wr_cnt_r;
  seg_t               rd_addr_r;
  logic               rd_pend_r;
  seg_t               arr_idx_r;
  logic [CW-1:0]      prev_x_r;
  logic [CW-1:0]      prev_y_r;
  logic               hold_v_r;
  tri_t               hold_r;
  logic               out_v_r;
  tri_t               out_r;
  logic [TOTAL_W-1:0] vcount_r;

  logic               out_free;
  logic               rd_en;
  logic               form_v;
  tri_t               form;
  logic [TOTAL_W:0]   vc_sum;
  logic               take_hold;
  logic               take_form;
  logic               put_hold;

  always_comb begin
    out_free = !out_v_r || !out_stall;
    // interlock: only read points already written for this ellipse
    rd_en = act_r && (rd_addr_r <= cnt_r) && (rd_addr_r < wr_cnt_r) && !hold_v_r &&
            !(rd_pend_r && !out_free);
    form_v     = rd_pend_r && (arr_idx_r != '0);
    vc_sum     = {1'b0, vcount_r} + (TOTAL_W+1)'(3);
    form.a_x   = prev_x_r;
    form.a_y   = prev_y_r;
    form.b_x   = rd_data_r[2*CW-1:CW];
    form.b_y   = rd_data_r[CW-1:0];
    form.last  = (arr_idx_r == cnt_r);
    form.total = vc_sum[TOTAL_W] ? '1 : vc_sum[TOTAL_W-1:0];
    take_hold  = hold_v_r && out_free;
    take_form  = form_v && out_free && !hold_v_r;
    put_hold   = form_v && !take_form;
  end

  always_ff @(posedge clk) begin
    if (wr_en)
      mem[wr_addr] <= {wr_x, wr_y};
    if (rd_en)
      rd_data_r <= mem[rd_addr_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= 1'b0;
      rd_pend_r <= 1'b0;
      hold_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
      vcount_r  <= '0;
      wr_cnt_r  <= '0;
      rd_addr_r <= '0;
      cnt_r     <= '0;
    end else begin
      rd_pend_r <= rd_en;
      if (ctl.go) begin
        act_r     <= 1'b1;
        cnt_r     <= ctl.count;
        wr_cnt_r  <= '0;
        rd_addr_r <= '0;
      end else begin
        if (done)
          act_r <= 1'b0;
        if (wr_en)
          wr_cnt_r <= wr_cnt_r + 1'b1;
        if (rd_en)
          rd_addr_r <= rd_addr_r + 1'b1;
      end
      if (form_v)
        vcount_r <= form.total;
      if (take_hold || take_form)
        out_v_r <= 1'b1;
      else if (out_free)
        out_v_r <= 1'b0;
      if (put_hold)
        hold_v_r <= 1'b1;
      else if (take_hold)
        hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en)
      arr_idx_r <= rd_addr_r;
    if (rd_pend_r) begin
      prev_x_r <= rd_data_r[2*CW-1:CW];
      prev_y_r <= rd_data_r[CW-1:0];
    end
    if (take_hold)
      out_r <= hold_r;
    else if (take_form)
      out_r <= form;
    if (put_hold)
      hold_r <= form;
  end

  assign out_valid = out_v_r;
  assign rim_a_x   = out_r.a_x;
  assign rim_a_y   = out_r.a_y;
  assign rim_b_x   = out_r.b_x;
  assign rim_b_y   = out_r.b_y;
  assign last      = out_r.last;
  assign total     = out_r.total;
  assign done      = out_v_r && !out_stall && out_r.last;

  a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r |-> out_v_r)
    else $error("skid word held while output register empty");

  a_no_hold_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (form_v && hold_v_r) |-> out_free)
    else $error("new triangle would overwrite a pending skid word");

  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (vcount_r >= $past(vcount_r)))
    else $error("vertex total went backward");

endmodule

### src/ellipse_triangle_fan_generator.sv
// Ellipse triangle fan generator, top level.
// Uses efg_pkg, efg_div, efg_rim, efg_emit.
//
// Input channel (in_*): one word is one ellipse request, accepted when in_valid is
// high and in_stall low. in_stall stays high from acceptance until the last
// triangle of that ellipse has been taken; a request with zero segments is
// accepted and produces nothing. Counts above MAX_SEGMENTS are clamped.
// Output channel (out_*): one word per triangle, in fan order, out_last_triangle
// on the final one, out_vertex_total the saturating running vertex count.
// Sequence for n triangles: the request is registered as the 360/n step divider
// starts (one quotient bit a cycle), then the rim pipeline writes one point a
// cycle into the point buffer while the readout follows it one read a cycle,
// holding off while the output is stalled or the skid stage is full.
// out_stall freezes the output word; a one-word skid stage catches the read in
// flight, and reads stop until space frees up.
// Reset (rst_n low, synchronous) clears the vertex total and all control state;
// the point buffer needs no clearing.
module ellipse_triangle_fan_generator
  import efg_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int COORD_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_center_y,
  input  logic signed [COORD_WIDTH-1:0] in_scale_x,
  input  logic signed [COORD_WIDTH-1:0] in_scale_y,
  input  logic [SEG_W-1:0]              in_segments,
  input  logic [COLOR_W-1:0]            in_red_in,
  input  logic [COLOR_W-1:0]            in_green_in,
  input  logic [COLOR_W-1:0]            in_blue_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_hub_x,
  output logic signed [COORD_WIDTH-1:0] out_hub_y,
  output logic signed [COORD_WIDTH-1:0] out_rim_a_x,
  output logic signed [COORD_WIDTH-1:0] out_rim_a_y,
  output logic signed [COORD_WIDTH-1:0] out_rim_b_x,
  output logic signed [COORD_WIDTH-1:0] out_rim_b_y,
  output logic [COLOR_W-1:0]            out_red_out,
  output logic [COLOR_W-1:0]            out_green_out,
  output logic [COLOR_W-1:0]            out_blue_out,
  output logic                          out_last_triangle,
  output logic [TOTAL_W-1:0]            out_vertex_total
);

  localparam int CW    = COORD_WIDTH;
  localparam int DEPTH = MAX_SEGMENTS + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam seg_t MAX_N = SEG_W'(MAX_SEGMENTS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0]           state_r;
  logic [1:0]           state_nxt;
  logic signed [CW-1:0] cx_r;
  logic signed [CW-1:0] cy_r;
  logic signed [CW-1:0] sx_r;
  logic signed [CW-1:0] sy_r;
  logic [COLOR_W-1:0]   red_r;
  logic [COLOR_W-1:0]   green_r;
  logic [COLOR_W-1:0]   blue_r;
  seg_t                 n_r;
  seg_t                 n_clamp;
  logic                 accept;
  logic                 start;
  logic                 div_done;
  ang_t                 quot;
  efg_ctl_t             ctl;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [CW-1:0]        wr_x;
  logic [CW-1:0]        wr_y;
  logic                 rim_done;
  logic                 emit_done;
  logic [CW-1:0]        a_x;
  logic [CW-1:0]        a_y;
  logic [CW-1:0]        b_x;
  logic [CW-1:0]        b_y;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign n_clamp  = (in_segments > MAX_N) ? MAX_N : in_segments;
  assign start    = accept && (in_segments != '0);

  always_comb begin
    ctl.go    = (state_r == ST_DIV) && div_done;
    ctl.count = n_r;
    ctl.step  = quot;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start)     state_nxt = ST_DIV;
      ST_DIV:  if (div_done)  state_nxt = ST_RUN;
      ST_RUN:  if (emit_done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cx_r    <= in_center_x;
      cy_r    <= in_center_y;
      sx_r    <= in_scale_x;
      sy_r    <= in_scale_y;
      red_r   <= in_red_in;
      green_r <= in_green_in;
      blue_r  <= in_blue_in;
      n_r     <= n_clamp;
    end
  end

  efg_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .divisor (n_clamp),
    .done    (div_done),
    .quot    (quot)
  );

  efg_rim #(
    .CW (CW),
    .AW (AW)
  ) u_rim (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .center_x (cx_r),
    .center_y (cy_r),
    .scale_x  (sx_r),
    .scale_y  (sy_r),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_x     (wr_x),
    .wr_y     (wr_y),
    .done     (rim_done)
  );

  efg_emit #(
    .CW    (CW),
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_x      (wr_x),
    .wr_y      (wr_y),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .rim_a_x   (a_x),
    .rim_a_y   (a_y),
    .rim_b_x   (b_x),
    .rim_b_y   (b_y),
    .last      (out_last_triangle),
    .total     (out_vertex_total),
    .done      (emit_done)
  );

  assign out_hub_x     = cx_r;
  assign out_hub_y     = cy_r;
  assign out_rim_a_x   = $signed(a_x);
  assign out_rim_a_y   = $signed(a_y);
  assign out_rim_b_x   = $signed(b_x);
  assign out_rim_b_y   = $signed(b_y);
  assign out_red_out   = red_r;
  assign out_green_out = green_r;
  assign out_blue_out  = blue_r;

  a_out_only_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_RUN))
    else $error("result word outside an active ellipse");

  a_rim_only_running: assert property (@(posedge clk) disable iff (!rst_n)
    rim_done |-> (state_r == ST_RUN))
    else $error("rim pipeline finished outside an active ellipse");

  a_div_only_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished while not dividing");

endmodule

### test/fan_checker.sv
`timescale 1ns / 1ps
// Checker for the ellipse triangle fan generator: predicts each triangle word from
// accepted requests and compares it with the words the block hands out.
// Depends on efg_pkg for field widths.
module fan_checker
  import efg_pkg::*;
#(
  parameter int CW      = 16,
  parameter int MAX_SEG = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic signed [CW-1:0] in_center_x,
  input  logic signed [CW-1:0] in_center_y,
  input  logic signed [CW-1:0] in_scale_x,
  input  logic signed [CW-1:0] in_scale_y,
  input  logic [SEG_W-1:0]     in_segments,
  input  logic [COLOR_W-1:0]   in_red_in,
  input  logic [COLOR_W-1:0]   in_green_in,
  input  logic [COLOR_W-1:0]   in_blue_in,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic signed [CW-1:0] out_hub_x,
  input  logic signed [CW-1:0] out_hub_y,
  input  logic signed [CW-1:0] out_rim_a_x,
  input  logic signed [CW-1:0] out_rim_a_y,
  input  logic signed [CW-1:0] out_rim_b_x,
  input  logic signed [CW-1:0] out_rim_b_y,
  input  logic [COLOR_W-1:0]   out_red_out,
  input  logic [COLOR_W-1:0]   out_green_out,
  input  logic [COLOR_W-1:0]   out_blue_out,
  input  logic                 out_last_triangle,
  input  logic [TOTAL_W-1:0]   out_vertex_total,
  output int                   fail_count,
  output int                   pending
);

  typedef struct {
    logic signed [CW-1:0] hub_x;
    logic signed [CW-1:0] hub_y;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
    logic                 last;
    logic [TOTAL_W-1:0]   total;
  } fan_tri_t;

  // round(16384 * sin(d)) for d = 0..90
  localparam int SINE_TBL [0:90] = '{
        0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
     2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
     5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
     8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
  };

  fan_tri_t           tri_expect_q[$];
  logic [TOTAL_W-1:0] vertex_total;

  function automatic longint sin_q14(input int unsigned deg);
    int unsigned a, q, r;
    longint      mag;
    a   = deg % 360;
    q   = a / 90;
    r   = a % 90;
    mag = (q % 2 == 1) ? SINE_TBL[90 - r] : SINE_TBL[r];
    return (q >= 2) ? -mag : mag;
  endfunction

  // Q.14 product rounded half up back to an integer (Q.0), then saturated
  function automatic logic signed [CW-1:0] rim_coord(input longint center, input longint radius,
                                                    input longint trig);
    longint hi, lo, v;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    v  = center + ((radius * trig + 8192) >>> 14);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CW-1:0];
  endfunction

  function void predict_fan();
    longint      cx, cy, sx, sy;
    int unsigned n, step, a0, a1, i;
    fan_tri_t    t;
    cx = longint'(in_center_x);
    cy = longint'(in_center_y);
    sx = longint'(in_scale_x);
    sy = longint'(in_scale_y);
    n  = 32'(in_segments);
    if (n == 0) return;
    if (n > MAX_SEG) n = MAX_SEG;
    step = 360 / n;
    for (i = 0; i < n; i++) begin
      a0 = 90 + i * step;
      a1 = 90 + (i + 1) * step;
      vertex_total = (vertex_total > 32'hFFFF_FFFC) ? 32'hFFFF_FFFF : vertex_total + 32'd3;
      t.hub_x = in_center_x;
      t.hub_y = in_center_y;
      t.a_x   = rim_coord(cx, sx, sin_q14(a0 + 90));
      t.a_y   = rim_coord(cy, sy, sin_q14(a0));
      t.b_x   = rim_coord(cx, sx, sin_q14(a1 + 90));
      t.b_y   = rim_coord(cy, sy, sin_q14(a1));
      t.red   = in_red_in;
      t.green = in_green_in;
      t.blue  = in_blue_in;
      t.last  = (i + 1 == n);
      t.total = vertex_total;
      tri_expect_q.insert(tri_expect_q.size(), t);
    end
  endfunction

  function void check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: mismatch on %s: expected %h, got %h", $realtime, name, want, got);
    end
  endfunction

  function void compare_word();
    fan_tri_t t;
    if (tri_expect_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: triangle word with no request pending", $realtime);
      return;
    end
    t = tri_expect_q.pop_front();
    check_field("hub_x", t.hub_x, out_hub_x);
    check_field("hub_y", t.hub_y, out_hub_y);
    check_field("rim_a_x", t.a_x, out_rim_a_x);
    check_field("rim_a_y", t.a_y, out_rim_a_y);
    check_field("rim_b_x", t.b_x, out_rim_b_x);
    check_field("rim_b_y", t.b_y, out_rim_b_y);
    check_field("red", t.red, out_red_out);
    check_field("green", t.green, out_green_out);
    check_field("blue", t.blue, out_blue_out);
    check_field("last_triangle", t.last, out_last_triangle);
    check_field("vertex_total", t.total, out_vertex_total);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      vertex_total = '0;
      tri_expect_q.delete();
    end else begin
      if (out_valid && !out_stall) compare_word();
      if (in_valid && !in_stall) predict_fan();
    end
    pending <= tri_expect_q.size();
  end

endmodule

### test/tb_ellipse_triangle_fan_generator.sv
`timescale 1ns / 1ps
// Testbench top for the ellipse triangle fan generator: drives ellipse requests and
// receiver stalls, gives the verdict. Depends on efg_pkg, fan_checker and the block.
module tb_ellipse_triangle_fan_generator
  import efg_pkg::*;
();

  localparam int CW             = 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [CW-1:0] in_center_x, in_center_y, in_scale_x, in_scale_y;
  logic [SEG_W-1:0]     in_segments;
  logic [COLOR_W-1:0]   in_red_in, in_green_in, in_blue_in;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [CW-1:0] out_hub_x, out_hub_y;
  logic signed [CW-1:0] out_rim_a_x, out_rim_a_y, out_rim_b_x, out_rim_b_y;
  logic [COLOR_W-1:0]   out_red_out, out_green_out, out_blue_out;
  logic                 out_last_triangle;
  logic [TOTAL_W-1:0]   out_vertex_total;
  int                   fail_count;
  int                   pending;
  int                   send_idle_pct;
  int                   recv_idle_pct = 75;
  bit                   hold_req;
  int                   idle_cycles;

  ellipse_triangle_fan_generator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_center_x(in_center_x), .in_center_y(in_center_y),
    .in_scale_x(in_scale_x), .in_scale_y(in_scale_y),
    .in_segments(in_segments),
    .in_red_in(in_red_in), .in_green_in(in_green_in), .in_blue_in(in_blue_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hub_x(out_hub_x), .out_hub_y(out_hub_y),
    .out_rim_a_x(out_rim_a_x), .out_rim_a_y(out_rim_a_y),
    .out_rim_b_x(out_rim_b_x), .out_rim_b_y(out_rim_b_y),
    .out_red_out(out_red_out), .out_green_out(out_green_out), .out_blue_out(out_blue_out),
    .out_last_triangle(out_last_triangle), .out_vertex_total(out_vertex_total)
  );

  fan_checker #(.CW(CW), .MAX_SEG(64)) fan_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_center_x(in_center_x), .in_center_y(in_center_y),
    .in_scale_x(in_scale_x), .in_scale_y(in_scale_y),
    .in_segments(in_segments),
    .in_red_in(in_red_in), .in_green_in(in_green_in), .in_blue_in(in_blue_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hub_x(out_hub_x), .out_hub_y(out_hub_y),
    .out_rim_a_x(out_rim_a_x), .out_rim_a_y(out_rim_a_y),
    .out_rim_b_x(out_rim_b_x), .out_rim_b_y(out_rim_b_y),
    .out_red_out(out_red_out), .out_green_out(out_green_out), .out_blue_out(out_blue_out),
    .out_last_triangle(out_last_triangle), .out_vertex_total(out_vertex_total),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_ellipse(input logic signed [CW-1:0] cx, input logic signed [CW-1:0] cy,
                              input logic signed [CW-1:0] sx, input logic signed [CW-1:0] sy,
                              input logic [SEG_W-1:0] seg, input logic [COLOR_W-1:0] r,
                              input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_center_x <= cx;
    in_center_y <= cy;
    in_scale_x  <= sx;
    in_scale_y  <= sy;
    in_segments <= seg;
    in_red_in   <= r;
    in_green_in <= g;
    in_blue_in  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3: return CW'($signed($urandom_range(8192)) - 4096);
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic send_random(input int seg_lo, input int seg_hi);
    logic [SEG_W-1:0] seg;
    int               pick;
    pick = $urandom_range(99);
    if (seg_lo > 0) seg = SEG_W'($urandom_range(seg_hi, seg_lo));
    else if (pick < 8) seg = '0;
    else if (pick < 16) seg = SEG_W'($urandom_range(127, 65));
    else if (pick < 30) seg = SEG_W'($urandom_range(64, 33));
    else seg = SEG_W'($urandom_range(32, 1));
    send_ellipse(rand_coord(), rand_coord(), rand_coord(), rand_coord(), seg,
                 COLOR_W'($urandom_range(255)), COLOR_W'($urandom_range(255)),
                 COLOR_W'($urandom_range(255)));
  endtask

  // hold the sender back until every predicted triangle has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_center_x <= '0;
    in_center_y <= '0;
    in_scale_x  <= '0;
    in_scale_y  <= '0;
    in_segments <= '0;
    in_red_in   <= '0;
    in_green_in <= '0;
    in_blue_in  <= '0;
    send_idle_pct = 6;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: step widths past 8 bits, clamping, zero segments, saturation
    send_ellipse(16'sh0000, 16'sh0000, 16'sh4000, 16'sh4000, 7'd1, 8'd0, 8'd0, 8'd0);
    send_ellipse(16'sh0000, 16'sh0000, 16'sh4000, 16'sh2000, 7'd2, 8'd255, 8'd255, 8'd255);
    send_ellipse(16'sh1000, -16'sh1000, 16'sh3000, 16'sh3000, 7'd3, 8'd1, 8'd128, 8'd127);
    send_ellipse(16'sh0100, 16'sh0200, 16'sh1000, 16'sh0800, 7'd0, 8'd9, 8'd9, 8'd9);
    send_ellipse(16'sh0000, 16'sh0000, 16'sh1000, 16'sh1000, 7'd4, 8'h55, 8'hAA, 8'h0F);
    send_ellipse(16'sh0000, 16'sh0000, 16'sh2000, 16'sh1000, 7'd6, 8'hF0, 8'h33, 8'hCC);
    send_ellipse(16'sh0400, 16'sh0400, 16'sh1000, 16'sh1000, 7'd7, 8'd10, 8'd20, 8'd30);
    send_ellipse(16'sh0000, 16'sh0000, 16'sh4000, 16'sh4000, 7'd64, 8'd200, 8'd100, 8'd50);
    send_ellipse(16'sh0000, 16'sh0000, 16'sh4000, 16'sh4000, 7'd65, 8'd1, 8'd2, 8'd3);
    send_ellipse(-16'sh2000, 16'sh2000, 16'sh1000, 16'sh1000, 7'd127, 8'd4, 8'd5, 8'd6);
    send_ellipse(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 7'd8, 8'd255, 8'd0, 8'd255);
    send_ellipse(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 7'd8, 8'd0, 8'd255, 8'd0);
    send_ellipse(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 7'd5, 8'd77, 8'd88, 8'd99);
    send_ellipse(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 7'd12, 8'd11, 8'd22, 8'd33);
    send_ellipse(16'sh1234, -16'sh1234, 16'sh0000, 16'sh0000, 7'd9, 8'd44, 8'd55, 8'd66);
    send_ellipse(16'sh0000, 16'sh0000, -16'sh1000, 16'sh0800, 7'd10, 8'd12, 8'd34, 8'd56);
    send_ellipse(16'sh0000, 16'sh0000, 16'sh0001, -16'sh0001, 7'd36, 8'd98, 8'd76, 8'd54);
    send_ellipse(16'sh0000, 16'sh0000, 16'sh4000, 16'sh4000, 7'd0, 8'd0, 8'd0, 8'd0);
    send_ellipse(16'sh3000, 16'sh3000, 16'sh6000, 16'sh6000, 7'd45, 8'd1, 8'd1, 8'd1);
    send_ellipse(-16'sh3000, -16'sh3000, 16'sh6000, -16'sh6000, 7'd60, 8'd2, 8'd2, 8'd2);

    repeat (80) send_random(0, 0);
    drain();

    send_idle_pct = 75;
    recv_idle_pct <= 6;
    repeat (70) send_random(0, 0);
    drain();

    // long receiver hold-off while requests keep coming, so the block backs up
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_req <= 1'b1;
    repeat (12) send_random(20, 64);
    repeat (70) send_random(0, 0);

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
